// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the button press classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define BPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bpc_pkg.sv =====
// Shared types, widths and constants of the button press classifier.
`default_nettype none

package bpc_pkg;

    localparam int TIME_W   = 32;
    localparam int THRESH_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LONG_EN  = 2'd2;

    localparam logic [THRESH_W-1:0] DEBOUNCE_MS_RST = 16'd20;
    localparam logic [THRESH_W-1:0] LONG_MS_RST     = 16'd1000;

    localparam logic LEVEL_RELEASED = 1'b1;
    localparam logic LEVEL_PRESSED  = 1'b0;

    typedef struct packed {
        logic [THRESH_W-1:0] debounce_ms;
        logic [THRESH_W-1:0] long_press_ms;
        logic                long_enable;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              level;
    } t_sample;

    typedef struct packed {
        logic long_press;
        logic short_press;
    } t_flags;

endpackage

`default_nettype wire

// ===== rtl/button_press_classifier_core.sv =====
// Top level of the button press classifier: sample register, classifier, result register.
// Each accepted sample (level, millisecond timestamp) yields one result with the short and
// long press flags as they stand after that sample. A sample is registered on acceptance and
// classified into the result register when that register is free or being emptied; one
// sample is taken every cycle while the result side keeps up. The only loop is the press
// state update, one subtract and two compares per sample. Registers are to be written
// through the configuration port only while no sample is in flight; the user is bound to
// this, the block itself does not enforce it.
`default_nettype none

module button_press_classifier_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    // [0] level, [32:1] now_ms, [39:33] zero
    input  wire logic [bpc_pkg::IN_TDATA_W-1:0]  s_tdata,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    // [0] short_press, [1] long_press, [7:2] zero
    output      logic [bpc_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                            i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  wire logic [bpc_pkg::THRESH_W-1:0]    i_cfg_wdata
);
    import bpc_pkg::*;

    `include "assert_macros.svh"

    t_cfg    cfg;
    t_flags  next_flags;

    logic    r_in_valid;
    t_sample r_in;
    logic    r_out_valid;
    t_flags  r_out;

    logic    advance;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bpc_classify u_classify (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_sample  (r_in),
        .i_cfg     (cfg),
        .o_flags   (next_flags)
    );

    // move the held sample on when the result register is free or being emptied
    assign advance  = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            r_in.level  <= s_tdata[0];
            r_in.now_ms <= s_tdata[TIME_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= next_flags;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(OUT_TDATA_W-2){1'b0}}, r_out.long_press, r_out.short_press};

    `BPC_ASSERT(a_flags_exclusive, i_clk, i_rst_n,
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]), "short and long flags both raised")
    `BPC_ASSERT(a_stall_cause, i_clk, i_rst_n,
        !s_tready |-> (r_in_valid && m_tvalid && !m_tready), "input stalled without output stall")
    `BPC_ASSERT_NEXT(a_advance_result, i_clk, i_rst_n,
        advance, m_tvalid, "classified sample did not reach the result register")
    `BPC_ASSERT_NEXT(a_accept_held, i_clk, i_rst_n,
        s_tvalid && s_tready, r_in_valid, "accepted transaction not held in sample register")

endmodule

`default_nettype wire

// ===== rtl/bpc_cfg_regs.sv =====
// Configuration register bank of the button press classifier.
`default_nettype none

module bpc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [bpc_pkg::THRESH_W-1:0]  i_cfg_wdata,
    output      bpc_pkg::t_cfg                 o_cfg
);
    import bpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= DEBOUNCE_MS_RST;
            r_cfg.long_press_ms <= LONG_MS_RST;
            r_cfg.long_enable   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IDX_DEBOUNCE: r_cfg.debounce_ms   <= i_cfg_wdata;
                CFG_IDX_LONG_MS:  r_cfg.long_press_ms <= i_cfg_wdata;
                CFG_IDX_LONG_EN:  r_cfg.long_enable   <= i_cfg_wdata[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/bpc_classify.sv =====
// Press state and the per-sample short/long classification step.
`default_nettype none

module bpc_classify (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire bpc_pkg::t_sample  i_sample,
    input  wire bpc_pkg::t_cfg     i_cfg,
    output      bpc_pkg::t_flags   o_flags
);
    import bpc_pkg::*;

    logic              r_prev_level;
    logic [TIME_W-1:0] r_press_start;
    t_flags            r_flags;

    logic              n_prev_level;
    logic [TIME_W-1:0] n_press_start;
    t_flags            n_flags;

    logic [TIME_W-1:0] dur;
    logic              meets_long;
    logic              meets_short;
    logic              pressed;
    logic              pressed_edge;
    logic              released_edge;

    always_comb begin
        dur           = i_sample.now_ms - r_press_start;
        meets_long    = i_cfg.long_enable &&
                        (dur >= {{(TIME_W-THRESH_W){1'b0}}, i_cfg.long_press_ms});
        meets_short   = dur >= {{(TIME_W-THRESH_W){1'b0}}, i_cfg.debounce_ms};
        pressed       = (i_sample.level == LEVEL_PRESSED);
        pressed_edge  = (r_prev_level == LEVEL_RELEASED) && pressed;
        released_edge = (r_prev_level == LEVEL_PRESSED) && !pressed;

        n_prev_level  = i_sample.level;
        n_press_start = r_press_start;
        n_flags       = r_flags;

        if (pressed_edge) begin
            n_press_start = i_sample.now_ms;
            n_flags       = '0;
        end else if (pressed && meets_long && !r_flags.long_press) begin
            n_flags.long_press  = 1'b1;
            n_flags.short_press = 1'b0;
        end else if (released_edge && meets_long) begin
            n_flags.long_press  = 1'b1;
            n_flags.short_press = 1'b0;
        end else if (released_edge && meets_short) begin
            n_flags.long_press  = 1'b0;
            n_flags.short_press = 1'b1;
        end else if (released_edge) begin
            // too short a press: hold both flags
            n_flags = r_flags;
        end else if (!pressed) begin
            n_flags = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level  <= LEVEL_RELEASED;
            r_press_start <= '0;
            r_flags       <= '0;
        end else if (i_advance) begin
            r_prev_level  <= n_prev_level;
            r_press_start <= n_press_start;
            r_flags       <= n_flags;
        end
    end

    assign o_flags = n_flags;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the button press classifier core.
`timescale 1ns / 1ps

module tb;
    import bpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
    localparam int HOLD_OFF_CYCLES = 90;
    localparam int REPORT_LIMIT    = 10;
    localparam longint TIMEOUT_NS  = 64'd15_000_000;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    // [0] level, [32:1] now_ms, [39:33] zero
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    // [0] short_press, [1] long_press, [7:2] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr  = '0;
    logic [THRESH_W-1:0]    i_cfg_wdata = '0;

    // Classifier state and register copies used for prediction
    t_cfg          cfg_model;
    logic          btn_level_q;
    logic [31:0]   press_stamp;
    logic          short_seen;
    logic          long_seen;

    t_flags        expected_flags[$];
    int            fail_count = 0;
    int            items_sent = 0;
    int            src_idle_pct = 0;
    int            sink_idle_pct = 0;
    logic          hold_off_arm = 1'b0;
    logic          hold_off_taken = 1'b0;
    int            hold_left = 0;
    logic [31:0]   clock_ms;

    button_press_classifier_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_flags classify_sample(input t_sample smp);
        logic [31:0] held_for;
        logic        fell;
        logic        rose;
        logic        long_met;
        t_flags      res;
        held_for = smp.now_ms - press_stamp;
        fell     = (btn_level_q == LEVEL_RELEASED) && (smp.level == LEVEL_PRESSED);
        rose     = (btn_level_q == LEVEL_PRESSED) && (smp.level == LEVEL_RELEASED);
        long_met = cfg_model.long_enable && (held_for >= {16'd0, cfg_model.long_press_ms});
        if (fell) begin
            press_stamp = smp.now_ms;
            short_seen  = 1'b0;
            long_seen   = 1'b0;
        end else if (smp.level == LEVEL_PRESSED && long_met && !long_seen) begin
            long_seen  = 1'b1;
            short_seen = 1'b0;
        end else if (rose && long_met) begin
            long_seen  = 1'b1;
            short_seen = 1'b0;
        end else if (rose && held_for >= {16'd0, cfg_model.debounce_ms}) begin
            short_seen = 1'b1;
            long_seen  = 1'b0;
        end else if (rose) begin
            // too short a press: hold both flags
        end else if (smp.level == LEVEL_RELEASED) begin
            short_seen = 1'b0;
            long_seen  = 1'b0;
        end
        btn_level_q = smp.level;
        res.short_press = short_seen;
        res.long_press  = long_seen;
        return res;
    endfunction

    // Offer one sample and hold it until the transaction completes
    task automatic send_sample(input logic lvl, input logic [31:0] stamp);
        t_sample smp;
        logic    ready_seen;
        begin
            smp.level  = lvl;
            smp.now_ms = stamp;
            while ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {7'd0, smp};
            ready_seen = 1'b0;
            while (!ready_seen) begin
                @(negedge i_clk);
                ready_seen = s_tready;
                @(posedge i_clk);
            end
            expected_flags.push_back(classify_sample(smp));
            items_sent++;
        end
    endtask

    task automatic wait_until_drained();
        begin
            s_tvalid <= 1'b0;
            while (expected_flags.size() != 0) @(posedge i_clk);
            repeat (4) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THRESH_W-1:0] val);
        begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= val;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            case (idx)
                CFG_IDX_DEBOUNCE: cfg_model.debounce_ms   = val;
                CFG_IDX_LONG_MS:  cfg_model.long_press_ms = val;
                CFG_IDX_LONG_EN:  cfg_model.long_enable   = val[0];
                default: ;
            endcase
            @(posedge i_clk);
        end
    endtask

    task automatic set_thresholds(input logic [15:0] db, input logic [15:0] lp, input logic en);
        begin
            wait_until_drained();
            write_reg(CFG_IDX_DEBOUNCE, db);
            write_reg(CFG_IDX_LONG_MS, lp);
            write_reg(CFG_IDX_LONG_EN, {15'd0, en});
        end
    endtask

    // Aim most press lengths at the threshold boundaries
    function automatic logic [31:0] pick_hold_time();
        logic [31:0] db;
        logic [31:0] lp;
        db = {16'd0, cfg_model.debounce_ms};
        lp = {16'd0, cfg_model.long_press_ms};
        case ($urandom_range(7))
            0: return (db == 0) ? 32'd0 : $urandom_range(db - 1);
            1: return db;
            2: return db + 1;
            3: return (lp > db) ? $urandom_range(lp, db) : db + $urandom_range(50);
            4: return lp;
            5: return (lp == 0) ? 32'd0 : lp - 1;
            6: return lp + $urandom_range(3000);
            default: return $urandom();
        endcase
    endfunction

    task automatic run_press_sequences(input int count);
        int          stop_at;
        int          held_n;
        int          tail_n;
        logic [31:0] press_t;
        logic [31:0] hold_t;
        begin
            stop_at = items_sent + count;
            while (items_sent < stop_at) begin
                if ($urandom_range(99) < 12) begin
                    send_sample(1'($urandom_range(1)), $urandom());
                end else begin
                    if ($urandom_range(15) == 0)
                        clock_ms = $urandom();
                    else
                        clock_ms = clock_ms + $urandom_range(200, 1);
                    press_t = clock_ms;
                    hold_t  = pick_hold_time();
                    held_n  = $urandom_range(3);
                    send_sample(LEVEL_PRESSED, press_t);
                    for (int k = 1; k <= held_n; k++)
                        send_sample(LEVEL_PRESSED,
                                    press_t + 32'((64'(hold_t) * k) / (held_n + 1)));
                    clock_ms = press_t + hold_t;
                    send_sample(LEVEL_RELEASED, clock_ms);
                    tail_n = $urandom_range(2);
                    for (int k = 0; k < tail_n; k++) begin
                        clock_ms = clock_ms + $urandom_range(30, 1);
                        send_sample(LEVEL_RELEASED, clock_ms);
                    end
                end
            end
        end
    endtask

    task automatic test_default_thresholds();
        begin
            send_sample(LEVEL_RELEASED, 32'd0);
            send_sample(LEVEL_PRESSED, 32'd100);
            // long detection is off after reset, so a very long hold raises no long flag
            send_sample(LEVEL_PRESSED, 32'd5000);
            send_sample(LEVEL_RELEASED, 32'd5000);
            send_sample(LEVEL_RELEASED, 32'd5001);
            send_sample(LEVEL_PRESSED, 32'd6000);
            send_sample(LEVEL_RELEASED, 32'd6019);
            send_sample(LEVEL_PRESSED, 32'd7000);
            send_sample(LEVEL_RELEASED, 32'd7020);
        end
    endtask

    task automatic test_long_press();
        begin
            set_thresholds(16'd20, 16'd50, 1'b1);
            // press just before the timer wraps
            send_sample(LEVEL_PRESSED, 32'hFFFF_FFFF);
            send_sample(LEVEL_PRESSED, 32'd48);
            send_sample(LEVEL_PRESSED, 32'd49);
            send_sample(LEVEL_PRESSED, 32'd500);
            send_sample(LEVEL_RELEASED, 32'd600);
            send_sample(LEVEL_RELEASED, 32'd601);
            send_sample(LEVEL_PRESSED, 32'd1000);
            send_sample(LEVEL_RELEASED, 32'd1049);
        end
    endtask

    task automatic test_zero_and_extreme_thresholds();
        begin
            set_thresholds(16'd0, 16'd0, 1'b1);
            write_reg(CFG_IDX_SPARE, 16'hFFFF);
            send_sample(LEVEL_PRESSED, 32'd0);
            send_sample(LEVEL_PRESSED, 32'd0);
            send_sample(LEVEL_RELEASED, 32'd0);
            set_thresholds(16'd0, 16'hFFFF, 1'b1);
            send_sample(LEVEL_PRESSED, 32'd77);
            send_sample(LEVEL_RELEASED, 32'd77);
            // timestamp running backwards reads as a huge duration
            send_sample(LEVEL_PRESSED, 32'd40000);
            send_sample(LEVEL_RELEASED, 32'd39999);
        end
    endtask

    task automatic test_random_presses();
        logic [15:0] db;
        begin
            src_idle_pct  = 27;
            sink_idle_pct = 81;
            db = 16'($urandom_range(300));
            set_thresholds(db, 16'(db + $urandom_range(3000)), 1'b1);
            run_press_sequences(125);
            set_thresholds(16'hFFFF, 16'hFFFF, 1'b1);
            run_press_sequences(125);

            src_idle_pct  = 81;
            sink_idle_pct = 27;
            db = 16'($urandom_range(300));
            set_thresholds(db, 16'(db + $urandom_range(3000)), 1'b0);
            run_press_sequences(125);
            set_thresholds(16'd0, 16'd0, 1'b1);
            run_press_sequences(125);

            src_idle_pct  = 0;
            sink_idle_pct = 0;
            db = 16'($urandom_range(300));
            set_thresholds(db, 16'(db + $urandom_range(3000)), 1'b1);
            run_press_sequences(125);
            set_thresholds(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                           1'($urandom_range(1)));
            run_press_sequences(125);
        end
    endtask

    task automatic test_result_backpressure();
        begin
            set_thresholds(16'd10, 16'd200, 1'b1);
            hold_off_arm <= 1'b1;
            run_press_sequences(30);
            wait_until_drained();
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off_arm && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_left      = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(negedge i_clk) begin
        t_flags got;
        t_flags want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_flags'(m_tdata[1:0]);
            if (expected_flags.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result with nothing pending: short %0b long %0b",
                             $realtime, got.short_press, got.long_press);
            end else begin
                want = expected_flags.pop_front();
                if (got.short_press !== want.short_press || got.long_press !== want.long_press) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: mismatch: want short %0b long %0b, got short %0b long %0b",
                                 $realtime, want.short_press, want.long_press,
                                 got.short_press, got.long_press);
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("button_press_classifier_core verification failed");
        $finish;
    end

    initial begin
        cfg_model.debounce_ms   = DEBOUNCE_MS_RST;
        cfg_model.long_press_ms = LONG_MS_RST;
        cfg_model.long_enable   = 1'b0;
        btn_level_q = LEVEL_RELEASED;
        press_stamp = '0;
        short_seen  = 1'b0;
        long_seen   = 1'b0;
        clock_ms    = $urandom();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_thresholds();
        test_long_press();
        test_zero_and_extreme_thresholds();
        test_random_presses();
        test_result_backpressure();

        wait_until_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && expected_flags.size() == 0) begin
            $display("button_press_classifier_core verification clean");
        end else begin
            $display("button_press_classifier_core verification failed");
        end
        $finish;
    end

endmodule
